FILE: design/tgcw_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// tgcw_pkg: shared definitions for the text grid cursor writer
// Field widths, reset colors, control byte codes, request and register codes.
// ============================================================================
package tgcw_pkg;

   localparam int COLS_DEF  = 96;
   localparam int ROWS_DEF  = 30;

   localparam int CHAR_W    = 7;
   localparam int COLOR_W   = 32;
   localparam int BYTE_W    = 8;
   localparam int REQ_W     = 2;
   localparam int CSR_IDX_W = 1;
   localparam int TAB_STOP  = 8;

   localparam logic [COLOR_W-1:0] DEFAULT_FG_RST = 32'hFFA9_B1D6;
   localparam logic [COLOR_W-1:0] BG_COLOR_RST   = 32'hFF1A_1B26;
   localparam logic [CHAR_W-1:0]  BLANK_CHAR     = 7'd32;

   localparam logic [BYTE_W-1:0] CH_BS    = 8'd8;
   localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
   localparam logic [BYTE_W-1:0] CH_DEL   = 8'd127;

   localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
   localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
   localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_FG = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BG_COLOR   = 1'b1;

   typedef struct packed {
      logic [CHAR_W-1:0]  chr;
      logic [COLOR_W-1:0] fg;
   } cell_type;

endpackage

FILE: design/text_grid_cursor_writer.sv
`timescale 1ns / 1ps
// ============================================================================
// text_grid_cursor_writer: character-cell text screen with cursor and scroll
// ROWS x COLS cell store with a ring of rows, cursor tracking and read-back.
// ============================================================================
// Every cell (character and foreground) lives in one synchronous RAM of
// ROWS*COLS entries; the screen is a ring of rows starting at top_row, so a
// scroll only advances top_row and blanks one physical row. One transaction
// is worked at a time and its result waits in an output register, so the
// next request is taken while that result is still stalled. A carriage
// return, a newline that does not scroll, a backspace at column 0, a tab
// that does not move, a read outside the screen and an unused request code
// pass only decode and the hand-off step; any other put byte adds the byte
// store step (only a printable byte is written), a read inside the screen
// waits for the RAM read data, a backspace that steps back blanks the cell
// stepped onto, a tab that moves blanks each cell it passes (up to 8), a
// newline or wrap that scrolls blanks the new bottom row, and clear blanks
// all ROWS*COLS cells; the RAM write port blanks one cell per cycle. A
// finished result that finds the output register full and stalled waits in
// the last step for as long as that stall lasts. After reset the block
// runs a clearing pass over all ROWS*COLS cells (2880 at 30x96) with
// req_stall high; configuration writes are taken during that pass.
// Registers: index 0 sets the foreground written into blanked cells, index
// 1 the background reported by reads.
// ============================================================================
module text_grid_cursor_writer #(
   parameter  int COLS  = tgcw_pkg::COLS_DEF,
   parameter  int ROWS  = tgcw_pkg::ROWS_DEF,
   localparam int ROW_W = $clog2(ROWS),
   localparam int COL_W = $clog2(COLS + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [tgcw_pkg::REQ_W-1:0]     req_type,
   input  logic [tgcw_pkg::BYTE_W-1:0]    req_ch,
   input  logic [tgcw_pkg::COLOR_W-1:0]   req_fg_color,
   input  logic [ROW_W-1:0]               req_row,
   input  logic [COL_W-1:0]               req_col,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [tgcw_pkg::CHAR_W-1:0]    rsp_cell_char,
   output logic [tgcw_pkg::COLOR_W-1:0]   rsp_cell_fg,
   output logic [tgcw_pkg::COLOR_W-1:0]   rsp_cell_bg,
   output logic [ROW_W-1:0]               rsp_cursor_row,
   output logic [COL_W-1:0]               rsp_cursor_col,
   output logic                           rsp_changed,
   // configuration write channel
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tgcw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tgcw_pkg::COLOR_W-1:0]   csr_wdata
);

   import tgcw_pkg::*;

   localparam int CELLS  = ROWS * COLS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int CELL_W = $bits(cell_type);

   localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
   localparam logic [ROW_W:0]    ROWS_X    = (ROW_W + 1)'(ROWS);
   localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLS - 1);
   localparam logic [COL_W-1:0]  COLS_C    = COL_W'(COLS);
   localparam logic [COL_W:0]    LAST_COLX = (COL_W + 1)'(COLS - 1);
   localparam logic [COL_W:0]    TAB_ADD   = (COL_W + 1)'(TAB_STOP);
   localparam logic [COL_W:0]    TAB_MASK  = ~((COL_W + 1)'(TAB_STOP - 1));
   localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLS);

   typedef enum logic [2:0] {
      ST_IDLE,     // wait for a request
      ST_EXEC,     // decode the held request, move the cursor
      ST_RUN,      // blank a run of cells in one physical row
      ST_PUT,      // store a printable byte at the cursor
      ST_RD_WAIT,  // RAM read data arrives
      ST_SWEEP,    // blank every cell (reset pass or clear request)
      ST_DONE      // hand the result to the output register
   } state_type;

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   state_type           state_ff,      state_in;
   logic                init_ff,       init_in;
   logic [ROW_W-1:0]    cur_row_ff,    cur_row_in;
   logic [COL_W-1:0]    cur_col_ff,    cur_col_in;
   logic [ROW_W-1:0]    top_row_ff,    top_row_in;
   logic [ADDR_W-1:0]   sweep_cnt_ff,  sweep_cnt_in;
   logic [COLOR_W-1:0]  default_fg_ff, default_fg_in;
   logic [COLOR_W-1:0]  bg_color_ff,   bg_color_in;
   logic                rsp_valid_ff,  rsp_valid_in;

   // held request
   logic [REQ_W-1:0]    op_ff,  op_in;
   logic [BYTE_W-1:0]   ch_ff,  ch_in;
   logic [COLOR_W-1:0]  fg_ff,  fg_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [COL_W-1:0]    col_ff, col_in;

   // blanking run
   logic [ADDR_W-1:0]   run_base_ff, run_base_in;
   logic [COL_W-1:0]    run_cnt_ff,  run_cnt_in;
   logic [COL_W-1:0]    run_last_ff, run_last_in;
   logic                run_put_ff,  run_put_in;

   // staged result
   logic [CHAR_W-1:0]   res_char_ff, res_char_in;
   logic [COLOR_W-1:0]  res_fg_ff,   res_fg_in;
   logic [COLOR_W-1:0]  res_bg_ff,   res_bg_in;
   logic                res_chg_ff,  res_chg_in;

   // output register
   logic [CHAR_W-1:0]   rsp_char_ff, rsp_char_in;
   logic [COLOR_W-1:0]  rsp_fg_ff,   rsp_fg_in;
   logic [COLOR_W-1:0]  rsp_bg_ff,   rsp_bg_in;
   logic [ROW_W-1:0]    rsp_row_ff,  rsp_row_in;
   logic [COL_W-1:0]    rsp_col_ff,  rsp_col_in;
   logic                rsp_chg_ff,  rsp_chg_in;

   // ---------------------------------------------------------------------
   // Handshakes
   // ---------------------------------------------------------------------
   logic req_fire;
   logic rsp_fire;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_fire  = rsp_valid_ff && !rsp_stall;
   assign csr_ready = 1'b1;

   // ---------------------------------------------------------------------
   // Decode of the held put byte
   // ---------------------------------------------------------------------
   logic is_lf, is_cr, is_bs, is_tab, is_other, printable;
   logic wrap_pend, on_last, need_nl, scroll, rd_hit;

   assign is_lf     = (ch_ff == CH_LF);
   assign is_cr     = (ch_ff == CH_CR);
   assign is_bs     = (ch_ff == CH_BS) || (ch_ff == CH_DEL);
   assign is_tab    = (ch_ff == CH_TAB);
   assign is_other  = !(is_lf || is_cr || is_bs || is_tab);
   assign printable = (ch_ff >= CH_SPACE) && (ch_ff < CH_DEL);
   assign wrap_pend = (cur_col_ff >= COLS_C);
   assign on_last   = (cur_row_ff == LAST_ROW);
   // a newline, or a pending wrap before an ordinary byte, moves down a row
   assign need_nl   = is_lf || (is_other && wrap_pend);
   assign scroll    = (op_ff == REQ_PUT) && need_nl && on_last;
   assign rd_hit    = ({1'b0, row_ff} < ROWS_X) && (col_ff < COLS_C);

   // next tab stop, clamped to the last column
   logic [COL_W:0]   tab_round;
   logic [COL_W-1:0] tab_target;
   logic             tab_go;

   assign tab_round  = ({1'b0, cur_col_ff} + TAB_ADD) & TAB_MASK;
   assign tab_target = (tab_round > LAST_COLX) ? LAST_COL : tab_round[COL_W-1:0];
   assign tab_go     = (cur_col_ff < tab_target);

   logic [ROW_W-1:0] top_next;
   assign top_next = (top_row_ff == LAST_ROW) ? '0 : top_row_ff + 1'b1;

   // ---------------------------------------------------------------------
   // Logical row to RAM row base. A scroll blanks the physical row that
   // is the old top, which becomes the new bottom row.
   // ---------------------------------------------------------------------
   logic [ROW_W-1:0]  lrow_sel;
   logic [ROW_W:0]    psum;
   logic [ROW_W:0]    pwrap;
   logic [ROW_W-1:0]  mul_prow;
   logic [ADDR_W-1:0] row_base;

   assign lrow_sel = (state_ff == ST_EXEC && op_ff == REQ_READ) ? row_ff : cur_row_ff;
   assign psum     = {1'b0, lrow_sel} + {1'b0, top_row_ff};
   assign pwrap    = (psum >= ROWS_X) ? psum - ROWS_X : psum;
   assign mul_prow = (state_ff == ST_EXEC && scroll) ? top_row_ff : pwrap[ROW_W-1:0];
   assign row_base = ADDR_W'(mul_prow) * COLS_A;

   // ---------------------------------------------------------------------
   // Cell RAM
   // ---------------------------------------------------------------------
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   cell_type          ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   cell_type          ram_rd_data;
   cell_type          blank_cell;

   // the reset pass writes the reset foreground, whatever has been configured
   assign blank_cell.chr = BLANK_CHAR;
   assign blank_cell.fg  = init_ff ? DEFAULT_FG_RST : default_fg_ff;

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = run_base_ff + ADDR_W'(run_cnt_ff);
      ram_wr_data = blank_cell;
      ram_rd_en   = 1'b0;
      ram_rd_addr = row_base + ADDR_W'(col_ff);
      case (state_ff)
         ST_SWEEP: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = sweep_cnt_ff;
         end
         ST_RUN: begin
            ram_wr_en   = 1'b1;
         end
         ST_PUT: begin
            ram_wr_en       = printable;
            ram_wr_addr     = row_base + ADDR_W'(cur_col_ff);
            ram_wr_data.chr = ch_ff[CHAR_W-1:0];
            ram_wr_data.fg  = fg_ff;
         end
         ST_EXEC: begin
            ram_rd_en = (op_ff == REQ_READ) && rd_hit;
         end
         default: begin
         end
      endcase
   end

   tgcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      init_in       = init_ff;
      cur_row_in    = cur_row_ff;
      cur_col_in    = cur_col_ff;
      top_row_in    = top_row_ff;
      sweep_cnt_in  = sweep_cnt_ff;
      default_fg_in = default_fg_ff;
      bg_color_in   = bg_color_ff;
      rsp_valid_in  = rsp_valid_ff;
      op_in         = op_ff;
      ch_in         = ch_ff;
      fg_in         = fg_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      run_base_in   = run_base_ff;
      run_cnt_in    = run_cnt_ff;
      run_last_in   = run_last_ff;
      run_put_in    = run_put_ff;
      res_char_in   = res_char_ff;
      res_fg_in     = res_fg_ff;
      res_bg_in     = res_bg_ff;
      res_chg_in    = res_chg_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_fg_in     = rsp_fg_ff;
      rsp_bg_in     = rsp_bg_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_chg_in    = rsp_chg_ff;

      // configuration writes land whenever they come
      if (csr_valid) begin
         case (csr_index)
            CSR_DEFAULT_FG: default_fg_in = csr_wdata;
            CSR_BG_COLOR:   bg_color_in   = csr_wdata;
            default: begin
            end
         endcase
      end

      // drop the output once taken
      if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in    = req_type;
               ch_in    = req_ch;
               fg_in    = req_fg_color;
               row_in   = req_row;
               col_in   = req_col;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            res_char_in = '0;
            res_fg_in   = '0;
            res_bg_in   = '0;
            res_chg_in  = 1'b0;
            run_put_in  = 1'b0;
            run_base_in = row_base;
            state_in    = ST_DONE;
            case (op_ff)
               REQ_PUT: begin
                  if (is_lf) begin
                     res_chg_in = 1'b1;
                     cur_col_in = '0;
                     if (!on_last) begin
                        cur_row_in = cur_row_ff + 1'b1;
                     end else begin
                        top_row_in  = top_next;
                        run_cnt_in  = '0;
                        run_last_in = LAST_COL;
                        state_in    = ST_RUN;
                     end
                  end else if (is_cr) begin
                     res_chg_in = 1'b1;
                     cur_col_in = '0;
                  end else if (is_bs) begin
                     // step back and blank the cell stepped onto
                     if (cur_col_ff != '0) begin
                        res_chg_in  = 1'b1;
                        cur_col_in  = cur_col_ff - 1'b1;
                        run_cnt_in  = cur_col_ff - 1'b1;
                        run_last_in = cur_col_ff - 1'b1;
                        state_in    = ST_RUN;
                     end
                  end else if (is_tab) begin
                     res_chg_in = 1'b1;
                     if (tab_go) begin
                        cur_col_in  = tab_target;
                        run_cnt_in  = cur_col_ff;
                        run_last_in = tab_target - 1'b1;
                        state_in    = ST_RUN;
                     end
                  end else begin
                     // wrap first if pending, then try to store the byte
                     state_in = ST_PUT;
                     if (wrap_pend) begin
                        cur_col_in = '0;
                        if (!on_last) begin
                           cur_row_in = cur_row_ff + 1'b1;
                        end else begin
                           res_chg_in  = 1'b1;
                           top_row_in  = top_next;
                           run_cnt_in  = '0;
                           run_last_in = LAST_COL;
                           run_put_in  = 1'b1;
                           state_in    = ST_RUN;
                        end
                     end
                  end
               end
               REQ_CLEAR: begin
                  res_chg_in   = 1'b1;
                  cur_row_in   = '0;
                  cur_col_in   = '0;
                  top_row_in   = '0;
                  sweep_cnt_in = '0;
                  state_in     = ST_SWEEP;
               end
               REQ_READ: begin
                  if (rd_hit) begin
                     state_in = ST_RD_WAIT;
                  end
               end
               default: begin
               end
            endcase
         end

         ST_RUN: begin
            run_cnt_in = run_cnt_ff + 1'b1;
            if (run_cnt_ff == run_last_ff) begin
               state_in = run_put_ff ? ST_PUT : ST_DONE;
            end
         end

         ST_PUT: begin
            if (printable) begin
               cur_col_in = cur_col_ff + 1'b1;
               res_chg_in = 1'b1;
            end
            state_in = ST_DONE;
         end

         ST_RD_WAIT: begin
            res_char_in = ram_rd_data.chr;
            res_fg_in   = ram_rd_data.fg;
            res_bg_in   = bg_color_ff;
            state_in    = ST_DONE;
         end

         ST_SWEEP: begin
            sweep_cnt_in = sweep_cnt_ff + 1'b1;
            if (sweep_cnt_ff == LAST_CELL) begin
               init_in  = 1'b0;
               state_in = init_ff ? ST_IDLE : ST_DONE;
            end
         end

         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = res_char_ff;
               rsp_fg_in    = res_fg_ff;
               rsp_bg_in    = res_bg_ff;
               rsp_row_in   = cur_row_ff;
               rsp_col_in   = cur_col_ff;
               rsp_chg_in   = res_chg_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Control state and output valid
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         init_ff       <= 1'b1;
         cur_row_ff    <= '0;
         cur_col_ff    <= '0;
         top_row_ff    <= '0;
         sweep_cnt_ff  <= '0;
         default_fg_ff <= DEFAULT_FG_RST;
         bg_color_ff   <= BG_COLOR_RST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         init_ff       <= init_in;
         cur_row_ff    <= cur_row_in;
         cur_col_ff    <= cur_col_in;
         top_row_ff    <= top_row_in;
         sweep_cnt_ff  <= sweep_cnt_in;
         default_fg_ff <= default_fg_in;
         bg_color_ff   <= bg_color_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      ch_ff       <= ch_in;
      fg_ff       <= fg_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      run_base_ff <= run_base_in;
      run_cnt_ff  <= run_cnt_in;
      run_last_ff <= run_last_in;
      run_put_ff  <= run_put_in;
      res_char_ff <= res_char_in;
      res_fg_ff   <= res_fg_in;
      res_bg_ff   <= res_bg_in;
      res_chg_ff  <= res_chg_in;
      rsp_char_ff <= rsp_char_in;
      rsp_fg_ff   <= rsp_fg_in;
      rsp_bg_ff   <= rsp_bg_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_chg_ff  <= rsp_chg_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_char  = rsp_char_ff;
   assign rsp_cell_fg    = rsp_fg_ff;
   assign rsp_cell_bg    = rsp_bg_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_changed    = rsp_chg_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
`ifndef SYNTH
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (cur_row_ff <= LAST_ROW) && (cur_col_ff <= COLS_C))
      else $error("cursor outside the screen");

   a_put_no_wrap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUT) |-> (cur_col_ff < COLS_C))
      else $error("byte stored while a wrap is still pending");

   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (run_cnt_ff <= run_last_ff))
      else $error("blanking run went past its last column");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_EXEC))
      else $error("accepted request not decoded next cycle");
`endif

endmodule

FILE: design/tgcw_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// tgcw_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ============================================================================
module tgcw_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
